@@ rtl/rgbhue_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB hue and HSP brightness package
// Shared widths and the pipeline stage record of the pixel converter.
// ----------------------------------------------------------------------------
package rgbhue_pkg;

  localparam int ChanW   = 8;
  localparam int FracW   = 16;
  localparam int SqW     = 2 * ChanW;
  localparam int HnumW   = 12;
  localparam int NumW    = 11;
  localparam int DenW    = 11;
  localparam int WsumW   = 26;
  localparam int RemW    = NumW + FracW;
  localparam int QuoW    = FracW + 1;
  localparam int RadW    = 34;
  localparam int RootW   = RadW + 1;
  localparam int ScaleW  = WsumW + 16;

  localparam int NumIter   = QuoW;
  localparam int NumStages = 3 + NumIter + 1;

  localparam logic [WsumW-1:0] WeightRed   = WsumW'(306);
  localparam logic [WsumW-1:0] WeightGreen = WsumW'(601);
  localparam logic [WsumW-1:0] WeightBlue  = WsumW'(117);

  typedef struct packed {
    logic                    gray;
    logic [SqW-1:0]          sq_r;
    logic [SqW-1:0]          sq_g;
    logic [SqW-1:0]          sq_b;
    logic [ChanW-1:0]        diff;
    logic signed [HnumW-1:0] hnum;
    logic [WsumW-1:0]        wsum;
    logic [RemW-1:0]         rem;
    logic [DenW-1:0]         den;
    logic [QuoW-1:0]         quo;
    logic [RadW-1:0]         rad;
    logic [RootW-1:0]        root;
    logic [FracW-1:0]        hue;
    logic [FracW-1:0]        bright;
  } rgbhue_stage_t;

endpackage

@@ rtl/rgbhue_pix_if.sv @@
// ----------------------------------------------------------------------------
// Pixel request channel
// Carries one 8-bit RGB pixel per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgbhue_pix_if import rgbhue_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

@@ rtl/rgbhue_res_if.sv @@
// ----------------------------------------------------------------------------
// Hue and brightness result channel
// Carries the hue, the HSP brightness and the gray flag of one pixel.
// ----------------------------------------------------------------------------
interface rgbhue_res_if import rgbhue_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [FracW-1:0] hue_fraction;
  logic [FracW-1:0] brightness_fraction;
  logic             is_gray;

  modport source (
    output valid, output hue_fraction, output brightness_fraction, output is_gray,
    input ready
  );
  modport sink (
    input valid, input hue_fraction, input brightness_fraction, input is_gray,
    output ready
  );

endinterface

@@ rtl/rgb_hue_and_hsp_brightness_top.sv @@
// Throughput: one pixel per cycle while the output is not stalled; the pipeline
// is 21 register stages deep, with 17 stages each resolving one bit of the hue
// quotient and one bit of the root.
// A stage takes a new pixel whenever it is empty or its successor moves.
// Reset clears every stage valid bit; the payload registers are not reset.
// ----------------------------------------------------------------------------
// RGB hue and HSP brightness converter
// Pipelined HSV hue by long division and HSP brightness by integer root.
// ----------------------------------------------------------------------------
module rgb_hue_and_hsp_brightness_top import rgbhue_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rgbhue_pix_if.sink   pix_i,
  rgbhue_res_if.source res_o
);

  rgbhue_stage_t             stage_d [NumStages];
  rgbhue_stage_t             stage_q [NumStages];
  logic [NumStages-1:0]      valid_q;
  logic [NumStages-1:0]      valid_in;
  logic [NumStages-1:0]      stage_rdy;

  // Stage 0: squares, channel extremes and the raw sector numerator.
  always_comb begin
    logic [ChanW-1:0] mx, mn;
    logic signed [HnumW-1:0] r_s, g_s, b_s, d_s;
    mx = pix_i.red;
    mn = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    r_s = $signed({4'b0000, pix_i.red});
    g_s = $signed({4'b0000, pix_i.green});
    b_s = $signed({4'b0000, pix_i.blue});
    stage_d[0]      = '0;
    stage_d[0].diff = mx - mn;
    d_s = $signed({4'b0000, stage_d[0].diff});
    stage_d[0].gray = (mx == mn);
    stage_d[0].sq_r = {8'b0, pix_i.red} * {8'b0, pix_i.red};
    stage_d[0].sq_g = {8'b0, pix_i.green} * {8'b0, pix_i.green};
    stage_d[0].sq_b = {8'b0, pix_i.blue} * {8'b0, pix_i.blue};
    if (mx == pix_i.red) begin
      stage_d[0].hnum = g_s - b_s;
    end else if (mx == pix_i.green) begin
      stage_d[0].hnum = (d_s <<< 1) + b_s - r_s;
    end else begin
      stage_d[0].hnum = (d_s <<< 2) + r_s - g_s;
    end
  end

  // Stage 1: weighted sum of squares, wrapped hue numerator, divisor 6d.
  always_comb begin
    logic signed [HnumW-1:0] six_d;
    stage_d[1]      = stage_q[0];
    stage_d[1].wsum = {10'b0, stage_q[0].sq_r} * WeightRed
                    + {10'b0, stage_q[0].sq_g} * WeightGreen
                    + {10'b0, stage_q[0].sq_b} * WeightBlue;
    stage_d[1].den  = {3'b000, stage_q[0].diff} * DenW'(6);
    six_d = $signed({1'b0, stage_d[1].den});
    if (stage_q[0].hnum < 0) begin
      stage_d[1].hnum = stage_q[0].hnum + six_d;
    end
  end

  // Stage 2: radicand s * 257^2 / 256 and dividend N * 65536 + 3d.
  always_comb begin
    logic [ScaleW-1:0] scaled;
    scaled = {stage_q[1].wsum, 16'b0}
           + {7'b0, stage_q[1].wsum, 9'b0}
           + {16'b0, stage_q[1].wsum};
    stage_d[2]      = stage_q[1];
    stage_d[2].rad  = scaled[ScaleW-1:8];
    stage_d[2].rem  = {stage_q[1].hnum[NumW-1:0], 16'b0}
                    + {19'b0, stage_q[1].diff} * RemW'(3);
    stage_d[2].quo  = '0;
    stage_d[2].root = '0;
  end

  // One quotient bit and one root bit per stage, most significant first.
  for (genvar g = 0; g < NumIter; g++) begin : gen_iter
    localparam int Sh = NumIter - 1 - g;
    always_comb begin
      logic [RemW:0]    dshift;
      logic [RootW-1:0] bitv;
      logic [RootW-1:0] trial;
      dshift = (RemW+1)'(stage_q[g+2].den) << Sh;
      bitv   = RootW'(1) << (2 * Sh);
      trial  = stage_q[g+2].root + bitv;
      stage_d[g+3] = stage_q[g+2];
      if ({1'b0, stage_q[g+2].rem} >= dshift) begin
        stage_d[g+3].rem     = stage_q[g+2].rem - dshift[RemW-1:0];
        stage_d[g+3].quo[Sh] = 1'b1;
      end
      if ({1'b0, stage_q[g+2].rad} >= trial) begin
        stage_d[g+3].rad  = stage_q[g+2].rad - trial[RadW-1:0];
        stage_d[g+3].root = (stage_q[g+2].root >> 1) + bitv;
      end else begin
        stage_d[g+3].root = stage_q[g+2].root >> 1;
      end
    end
  end

  // Final stage: round the root to nearest and clear the hue of gray pixels.
  always_comb begin
    logic [QuoW:0] rnd;
    rnd = {1'b0, stage_q[NumStages-2].root[QuoW-1:0]} + (QuoW+1)'(1);
    stage_d[NumStages-1]        = stage_q[NumStages-2];
    stage_d[NumStages-1].bright = rnd[QuoW-1:1];
    stage_d[NumStages-1].hue    = stage_q[NumStages-2].gray ? '0
                                : stage_q[NumStages-2].quo[FracW-1:0];
  end

  // A stage loads when it is empty or its contents move on.
  assign stage_rdy[NumStages-1] = !valid_q[NumStages-1] || res_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : gen_rdy
    assign stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
  end

  assign valid_in[0] = pix_i.valid;
  for (genvar k = 1; k < NumStages; k++) begin : gen_vin
    assign valid_in[k] = valid_q[k-1];
  end

  for (genvar k = 0; k < NumStages; k++) begin : gen_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_rdy[k]) begin
        valid_q[k] <= valid_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign pix_i.ready               = stage_rdy[0];
  assign res_o.valid               = valid_q[NumStages-1];
  assign res_o.hue_fraction        = stage_q[NumStages-1].hue;
  assign res_o.brightness_fraction = stage_q[NumStages-1].bright;
  assign res_o.is_gray             = stage_q[NumStages-1].gray;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB hue and HSP brightness converter testbench
// Streams directed and random pixels through the converter with random gaps
// on both sides and long output stalls, and checks every hue, brightness and
// gray flag against an integer model of the conversion.
// ----------------------------------------------------------------------------
module tb_top;
  import rgbhue_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FracW-1:0] hue;
    logic [FracW-1:0] bright;
    logic             gray;
  } hue_bright_t;

  localparam int unsigned HoldCycles = 150;
  localparam int unsigned HoldSpacing = 350;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomPixels = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rgbhue_pix_if pix ();
  rgbhue_res_if res ();

  rgb_hue_and_hsp_brightness_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res)
  );

  pixel_t      pixel_q[$];
  hue_bright_t expected_q[$];
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned mismatch_cnt;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned hold_left;
  int unsigned hold_at;
  logic        hold_on;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    res.ready = 1'b0;
  end

  function automatic hue_bright_t convert_pixel(pixel_t p);
    int                mx;
    int                mn;
    int                d;
    int                n;
    longint unsigned   r;
    longint unsigned   g;
    longint unsigned   b;
    longint unsigned   radicand;
    longint unsigned   root;
    longint unsigned   trial;
    hue_bright_t       o;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = int'(p.red);
    mn = int'(p.red);
    if (int'(p.green) > mx) mx = int'(p.green);
    if (int'(p.blue) > mx) mx = int'(p.blue);
    if (int'(p.green) < mn) mn = int'(p.green);
    if (int'(p.blue) < mn) mn = int'(p.blue);
    d = mx - mn;
    o.gray = (d == 0);
    o.hue = '0;
    if (d != 0) begin
      if (mx == int'(p.red)) begin
        n = int'(p.green) - int'(p.blue);
      end else if (mx == int'(p.green)) begin
        n = 2 * d + int'(p.blue) - int'(p.red);
      end else begin
        n = 4 * d + int'(p.red) - int'(p.green);
      end
      if (n < 0) n += 6 * d;
      o.hue = FracW'((longint'(n) * 65536 + 3 * d) / (6 * d));
    end
    radicand = ((WeightRed * r * r + WeightGreen * g * g + WeightBlue * b * b) * 66049) >> 8;
    root = 0;
    for (int i = 20; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= radicand) root = trial;
    end
    o.bright = FracW'((root + 1) >> 1);
    return o;
  endfunction

  function automatic int unsigned draw_wait(int unsigned idx);
    if ((idx / 64) % 3 == 2) return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("mismatch: %s", msg);
  endtask

  task automatic add_pixel(int unsigned r, int unsigned g, int unsigned b);
    pixel_t p;
    p.red = ChanW'(r);
    p.green = ChanW'(g);
    p.blue = ChanW'(b);
    pixel_q.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    int unsigned w;
    logic        holding;
    pixel_t      p;
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.red <= '0;
      pix.green <= '0;
      pix.blue <= '0;
      tx_wait <= 0;
      pixels_sent <= 0;
    end else begin
      w = tx_wait;
      holding = pix.valid && !pix.ready;
      if (pix.valid && pix.ready) begin
        p.red = pix.red;
        p.green = pix.green;
        p.blue = pix.blue;
        expected_q.push_back(convert_pixel(p));
        pixels_sent <= pixels_sent + 1;
        w = hold_on ? 0 : draw_wait(pixels_sent);
      end else if (!pix.valid && w != 0) begin
        w = w - 1;
      end
      if (!holding) begin
        if (w == 0 && pixel_q.size() != 0) begin
          p = pixel_q.pop_front();
          pix.valid <= 1'b1;
          pix.red <= p.red;
          pix.green <= p.green;
          pix.blue <= p.blue;
        end else begin
          pix.valid <= 1'b0;
        end
      end
      tx_wait <= w;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned w;
    hue_bright_t want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
      rx_wait <= 0;
      results_seen <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending",
                                    results_seen));
        end else begin
          want = expected_q.pop_front();
          if (res.hue_fraction !== want.hue)
            report_mismatch($sformatf("result %0d hue_fraction got %h expected %h",
                                      results_seen, res.hue_fraction, want.hue));
          if (res.brightness_fraction !== want.bright)
            report_mismatch($sformatf("result %0d brightness_fraction got %h expected %h",
                                      results_seen, res.brightness_fraction, want.bright));
          if (res.is_gray !== want.gray)
            report_mismatch($sformatf("result %0d is_gray got %b expected %b",
                                      results_seen, res.is_gray, want.gray));
        end
        results_seen <= results_seen + 1;
        w = draw_wait(results_seen);
      end else if (rx_wait != 0) begin
        w = rx_wait - 1;
      end else begin
        w = 0;
      end
      rx_wait <= w;
      res.ready <= (w == 0) && !hold_on;
    end
  end

  // Long output stalls so that the pipeline fills and backs up into the input.
  always @(posedge clk_i or negedge rst_ni) begin : stall
    if (!rst_ni) begin
      hold_left <= 0;
      hold_at <= 40;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= hold_at) begin
      hold_left <= HoldCycles;
      hold_at <= hold_at + HoldSpacing;
    end
  end

  assign hold_on = (hold_left != 0);

  initial begin : stimulus
    int unsigned total;
    int unsigned kind;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(255, 0, 1);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(255, 254, 254);
    add_pixel(254, 255, 255);
    add_pixel(1, 1, 0);
    add_pixel(200, 100, 150);
    add_pixel(10, 20, 255);
    add_pixel(170, 85, 255);
    add_pixel(1, 255, 0);
    repeat (RandomPixels) begin
      kind = $urandom_range(0, 9);
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        4: begin
          g = r ^ $urandom_range(0, 3);
          b = r ^ $urandom_range(0, 3);
        end
        default: ;
      endcase
      add_pixel(r, g, b);
    end
    total = pixel_q.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pixels_sent != total) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS rgb_hue_and_hsp_brightness_top");
    end else begin
      $display("FAIL rgb_hue_and_hsp_brightness_top");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL rgb_hue_and_hsp_brightness_top");
    $finish;
  end

endmodule
